// File: design/xet_pkg.sv
//------------------------------------------------------------------------------
// xet_pkg
// Shared types, constants and helpers for the XML event tokenizer.
//------------------------------------------------------------------------------
`default_nettype none

package xet_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int FIELD_W     = 24;
	// span arithmetic width: room for position plus small look-ahead offsets
	localparam int CALC_W      = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 2;
	localparam int CNT_W       = 8;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int TDATA_OUT_W = 112;

	localparam logic [OFFSET_BITS-1:0] POS_MAX   = {OFFSET_BITS{1'b1}};
	localparam logic [FIELD_W-1:0]     FIELD_MAX = {FIELD_W{1'b1}};
	localparam logic [CNT_W-1:0]       CNT_MAX   = {CNT_W{1'b1}};

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [CALC_W-1:0] COMMENT_SKIP = CALC_W'(3);
	localparam logic [CALC_W-1:0] COMMENT_TAIL = CALC_W'(2);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_TEXT    = 4'd1,
		PH_LT      = 4'd2,
		PH_NAME    = 4'd3,
		PH_ATTRS   = 4'd4,
		PH_ANAME   = 4'd5,
		PH_SEEKQ   = 4'd6,
		PH_AVAL    = 4'd7,
		PH_SLASH   = 4'd8,
		PH_CLOSE   = 4'd9,
		PH_DECL    = 4'd10,
		PH_COMMENT = 4'd11
	} phase_t;

	typedef enum logic [2:0] {
		EV_TEXT    = 3'd0,
		EV_OPEN    = 3'd1,
		EV_CLOSE   = 3'd2,
		EV_COMMENT = 3'd3,
		EV_DECL    = 3'd4,
		EV_ATTR    = 3'd5,
		EV_BAD     = 3'd6,
		EV_END     = 3'd7
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t           kind;
		logic [FIELD_W-1:0] name_offset;
		logic [FIELD_W-1:0] name_length;
		logic [FIELD_W-1:0] value_offset;
		logic [FIELD_W-1:0] value_length;
		logic [CNT_W-1:0]   attr_total;
		logic               empty_element;
		logic               run_last;
	} event_t;

	// events produced by one byte, in order
	typedef struct packed {
		logic [1:0] count;
		event_t     ev0;
		event_t     ev1;
	} event_pair_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b inside {8'h20, 8'h09, 8'h0A, 8'h0D});
	endfunction

	function automatic logic [FIELD_W-1:0] span_len(input logic [CALC_W-1:0] e,
			input logic [CALC_W-1:0] s);
		logic [CALC_W-1:0] d;
		d = (e > s) ? (e - s) : '0;
		return (d > CALC_W'(FIELD_MAX)) ? FIELD_MAX : d[FIELD_W-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] to_off(input logic [CALC_W-1:0] v);
		return v[FIELD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: design/xml_event_tokenizer_core.sv
//------------------------------------------------------------------------------
// xml_event_tokenizer_core
// Streaming XML tokenizer: one document byte in, text/tag/attribute events out.
//------------------------------------------------------------------------------
// Usage:
//   s_axis carries one document byte per transfer in tdata, with tlast on the
//   final byte; a zero byte also ends the document and is not counted.
//   m_axis carries events: kind in tuser, spans and counts in tdata, tlast on
//   the last event caused by one input byte.
//   cfg_wr_en/cfg_wr_data write skip_comments; write only while idle.
// Timing:
//   a byte lands in the input register, is parsed there and its events are
//   written into the event queue, which drives m_axis. One byte per cycle
//   is taken while the queue has room; a byte that raises two events
//   (any text, tag, comment, declaration or attribute event together with
//   document end, or a malformed event followed by document end) occupies
//   two queue entries. Throughput is bounded by the one-event-per-cycle
//   output queue.
// Reset and stall:
//   reset clears the parse state, position and queue and sets skip_comments
//   to 0. When m_axis_tready is low the four-entry event queue fills and
//   s_axis_tready drops once fewer than two slots remain free while the
//   input register holds a byte.
//------------------------------------------------------------------------------
`default_nettype none

module xml_event_tokenizer_core import xet_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic                   cfg_wr_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [7:0]             s_axis_tdata,  // doc_byte
	input  wire logic                   s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// name_offset, name_length, value_offset, value_length, attr_total,
	// empty_element, zero pad
	output logic [TDATA_OUT_W-1:0]      m_axis_tdata,
	output logic [2:0]                  m_axis_tuser,  // event_kind
	output logic                        m_axis_tlast
);

	logic        skip_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        room;
	logic        advance;
	event_pair_t events;
	event_t      out_event;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				skip_q <= cfg_wr_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	xet_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.doc_byte      (byte_s1),
		.doc_end       (last_s1),
		.skip_comments (skip_q),
		.events        (events)
	);

	xet_event_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.events    (events),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_event (out_event)
	);

	assign m_axis_tuser = out_event.kind;
	assign m_axis_tlast = out_event.run_last;
	assign m_axis_tdata = {
		7'd0,
		out_event.empty_element,
		out_event.attr_total,
		out_event.value_length,
		out_event.value_offset,
		out_event.name_length,
		out_event.name_offset
	};

endmodule

`default_nettype wire

// File: design/xet_parser.sv
//------------------------------------------------------------------------------
// xet_parser
// Parse state and per-byte event logic; yields up to two events per byte.
//------------------------------------------------------------------------------
`default_nettype none

module xet_parser import xet_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  doc_byte,
	input  wire logic        doc_end,
	input  wire logic        skip_comments,
	output event_pair_t      events
);

	phase_t                 phase_q, phase_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [CALC_W-1:0]      span_start_q, span_start_d;
	logic [CALC_W-1:0]      span_end_q, span_end_d;
	logic [CALC_W-1:0]      an_start_q, an_start_d;
	logic [CALC_W-1:0]      an_end_q, an_end_d;
	logic [CALC_W-1:0]      av_start_q, av_start_d;
	logic [7:0]             quote_q, quote_d;
	logic [CNT_W-1:0]       depth_q, depth_d;
	logic [CNT_W-1:0]       attr_cnt_q, attr_cnt_d;
	logic                   self_close_q, self_close_d;
	logic [7:0]             prev_q, prev_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			pos_q        <= '0;
			span_start_q <= '0;
			span_end_q   <= '0;
			an_start_q   <= '0;
			an_end_q     <= '0;
			av_start_q   <= '0;
			quote_q      <= '0;
			depth_q      <= '0;
			attr_cnt_q   <= '0;
			self_close_q <= 1'b0;
			prev_q       <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			span_start_q <= span_start_d;
			span_end_q   <= span_end_d;
			an_start_q   <= an_start_d;
			an_end_q     <= an_end_d;
			av_start_q   <= av_start_d;
			quote_q      <= quote_d;
			depth_q      <= depth_d;
			attr_cnt_q   <= attr_cnt_d;
			self_close_q <= self_close_d;
			prev_q       <= prev_d;
		end
	end

	always_comb begin
		logic [CALC_W-1:0] pos_x;
		logic [CALC_W-1:0] name_end;
		logic              trail_slash;
		logic              hit;
		logic              doc_done;
		event_t            ev_a;
		event_t            ev_bad;
		event_t            ev_end;
		logic              bad;

		pos_x        = CALC_W'(pos_q);
		phase_d      = phase_q;
		pos_d        = pos_q;
		span_start_d = span_start_q;
		span_end_d   = span_end_q;
		an_start_d   = an_start_q;
		an_end_d     = an_end_q;
		av_start_d   = av_start_q;
		quote_d      = quote_q;
		depth_d      = depth_q;
		attr_cnt_d   = attr_cnt_q;
		self_close_d = self_close_q;
		prev_d       = prev_q;
		ev_a         = '0;
		hit          = 1'b0;
		trail_slash  = (pos_x > span_start_q) && (prev_q == CH_SLASH);
		name_end     = trail_slash ? (pos_x - CALC_W'(1)) : pos_x;

		if (doc_byte != CH_NUL) begin
			case (phase_q)
				PH_TEXT: begin
					if (doc_byte == CH_LT) begin
						ev_a.kind        = EV_TEXT;
						ev_a.name_offset = to_off(span_start_q);
						ev_a.name_length = span_len(pos_x, span_start_q);
						hit              = 1'b1;
						phase_d          = PH_LT;
					end
				end
				PH_LT: begin
					if (doc_byte == CH_SLASH) begin
						span_start_d = pos_x + CALC_W'(1);
						phase_d      = PH_CLOSE;
					end else if (doc_byte == CH_QMARK) begin
						span_start_d = pos_x + CALC_W'(1);
						phase_d      = PH_DECL;
					end else if (doc_byte == CH_BANG) begin
						span_start_d = pos_x + COMMENT_SKIP;
						depth_d      = CNT_W'(1);
						phase_d      = PH_COMMENT;
					end else begin
						// first name byte; an immediate '>' or blank gives an empty name
						span_start_d = pos_x;
						span_end_d   = pos_x;
						attr_cnt_d   = '0;
						self_close_d = 1'b0;
						if (doc_byte == CH_GT) begin
							ev_a.kind        = EV_OPEN;
							ev_a.name_offset = to_off(pos_x);
							hit              = 1'b1;
							phase_d          = PH_IDLE;
						end else if (is_ws(doc_byte)) begin
							phase_d = PH_ATTRS;
						end else begin
							phase_d = PH_NAME;
						end
					end
				end
				PH_NAME: begin
					if (doc_byte == CH_GT || is_ws(doc_byte)) begin
						span_end_d   = name_end;
						self_close_d = self_close_q | trail_slash;
						if (doc_byte == CH_GT) begin
							ev_a.kind          = EV_OPEN;
							ev_a.name_offset   = to_off(span_start_q);
							ev_a.name_length   = span_len(name_end, span_start_q);
							ev_a.attr_total    = attr_cnt_q;
							ev_a.empty_element = self_close_q | trail_slash;
							hit                = 1'b1;
							phase_d            = PH_IDLE;
						end else begin
							phase_d = PH_ATTRS;
						end
					end
				end
				PH_ATTRS: begin
					if (!is_ws(doc_byte)) begin
						if (doc_byte == CH_GT) begin
							ev_a.kind          = EV_OPEN;
							ev_a.name_offset   = to_off(span_start_q);
							ev_a.name_length   = span_len(span_end_q, span_start_q);
							ev_a.attr_total    = attr_cnt_q;
							ev_a.empty_element = self_close_q;
							hit                = 1'b1;
							phase_d            = PH_IDLE;
						end else if (doc_byte == CH_SLASH) begin
							self_close_d = 1'b1;
							phase_d      = PH_SLASH;
						end else begin
							an_start_d = pos_x;
							phase_d    = PH_ANAME;
						end
					end
				end
				PH_ANAME: begin
					if (is_ws(doc_byte) || doc_byte == CH_EQ) begin
						an_end_d = pos_x;
						phase_d  = PH_SEEKQ;
					end
				end
				PH_SEEKQ: begin
					if (doc_byte == CH_DQUOT || doc_byte == CH_SQUOT) begin
						quote_d    = doc_byte;
						av_start_d = pos_x + CALC_W'(1);
						phase_d    = PH_AVAL;
					end
				end
				PH_AVAL: begin
					if (doc_byte == quote_q) begin
						ev_a.kind         = EV_ATTR;
						ev_a.name_offset  = to_off(an_start_q);
						ev_a.name_length  = span_len(an_end_q, an_start_q);
						ev_a.value_offset = to_off(av_start_q);
						ev_a.value_length = span_len(pos_x, av_start_q);
						ev_a.attr_total   = attr_cnt_q;
						hit               = 1'b1;
						if (attr_cnt_q != CNT_MAX) begin
							attr_cnt_d = attr_cnt_q + CNT_W'(1);
						end
						phase_d = PH_ATTRS;
					end
				end
				PH_SLASH: begin
					// any byte after a slash among attributes ends the element
					ev_a.kind          = EV_OPEN;
					ev_a.name_offset   = to_off(span_start_q);
					ev_a.name_length   = span_len(span_end_q, span_start_q);
					ev_a.attr_total    = attr_cnt_q;
					ev_a.empty_element = self_close_q;
					hit                = 1'b1;
					phase_d            = PH_IDLE;
				end
				PH_CLOSE, PH_DECL: begin
					if (doc_byte == CH_GT) begin
						ev_a.kind        = (phase_q == PH_CLOSE) ? EV_CLOSE : EV_DECL;
						ev_a.name_offset = to_off(span_start_q);
						ev_a.name_length = span_len(pos_x, span_start_q);
						hit              = 1'b1;
						phase_d          = PH_IDLE;
					end
				end
				PH_COMMENT: begin
					if (doc_byte == CH_GT) begin
						if (depth_q <= CNT_W'(1)) begin
							depth_d = '0;
							phase_d = PH_IDLE;
							if (!skip_comments) begin
								ev_a.kind        = EV_COMMENT;
								ev_a.name_offset = to_off(span_start_q);
								ev_a.name_length = span_len(pos_x,
									span_start_q + COMMENT_TAIL);
								hit              = 1'b1;
							end
						end else begin
							depth_d = depth_q - CNT_W'(1);
						end
					end else if (doc_byte == CH_LT && depth_q != CNT_MAX) begin
						depth_d = depth_q + CNT_W'(1);
					end
				end
				default: begin
					if (!is_ws(doc_byte)) begin
						if (doc_byte == CH_LT) begin
							phase_d = PH_LT;
						end else begin
							span_start_d = pos_x;
							phase_d      = PH_TEXT;
						end
					end else begin
						phase_d = PH_IDLE;
					end
				end
			endcase
			prev_d = doc_byte;
			if (pos_q != POS_MAX) begin
				pos_d = pos_q + OFFSET_BITS'(1);
			end
		end

		doc_done = (doc_byte == CH_NUL) || doc_end;
		bad      = doc_done && (phase_d == PH_SEEKQ || phase_d == PH_AVAL);

		ev_bad             = '0;
		ev_bad.kind        = EV_BAD;
		ev_bad.name_offset = to_off(span_start_d);
		ev_bad.name_length = span_len(span_end_d, span_start_d);
		ev_bad.attr_total  = attr_cnt_d;

		ev_end             = '0;
		ev_end.kind        = EV_END;
		ev_end.name_length = span_len(CALC_W'(pos_d), '0);

		if (doc_done) begin
			phase_d      = PH_IDLE;
			pos_d        = '0;
			span_start_d = '0;
			span_end_d   = '0;
			an_start_d   = '0;
			an_end_d     = '0;
			av_start_d   = '0;
			quote_d      = '0;
			depth_d      = '0;
			attr_cnt_d   = '0;
			self_close_d = 1'b0;
			prev_d       = '0;
		end

		// pack in order: byte event, malformed, document end
		events = '0;
		if (hit) begin
			events.ev0 = ev_a;
			if (doc_done) begin
				events.ev1          = ev_end;
				events.ev1.run_last = 1'b1;
				events.count        = 2'd2;
			end else begin
				events.ev0.run_last = 1'b1;
				events.count        = 2'd1;
			end
		end else if (bad) begin
			events.ev0          = ev_bad;
			events.ev1          = ev_end;
			events.ev1.run_last = 1'b1;
			events.count        = 2'd2;
		end else if (doc_done) begin
			events.ev0          = ev_end;
			events.ev0.run_last = 1'b1;
			events.count        = 2'd1;
		end
	end

endmodule

`default_nettype wire

// File: design/xet_event_fifo.sv
//------------------------------------------------------------------------------
// xet_event_fifo
// Small event queue taking up to two events per cycle and giving one.
//------------------------------------------------------------------------------
`default_nettype none

module xet_event_fifo import xet_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  event_pair_t      events,
	output logic             room,
	output logic             out_valid,
	input  wire logic        out_ready,
	output event_t           out_event
);

	localparam int CNT_BITS = FIFO_PTR_W + 1;

	event_t                ent_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [1:0]            n_push;
	logic                  pop;
	logic [FIFO_PTR_W-1:0] wr_ptr_p1;

	assign n_push    = push ? events.count : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_event = ent_q[rd_ptr_q];
	// two free slots needed since a byte can raise two events
	assign room      = (count_q <= CNT_BITS'(FIFO_DEPTH - 2));
	assign wr_ptr_p1 = wr_ptr_q + FIFO_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			ent_q[wr_ptr_q] <= events.ev0;
		end
		if (n_push == 2'd2) begin
			ent_q[wr_ptr_p1] <= events.ev1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + CNT_BITS'(n_push) - CNT_BITS'(pop);
		end
	end

endmodule

`default_nettype wire
